@@ rtl/core/wbwc_pkg.sv @@
// Shared types and constants for the WOTS+ base-w digit and checksum block.
package wbwc_pkg;

  localparam int DIGIT_W     = 4;
  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int MAX_DIGITS  = 9;
  localparam int SLOT_W      = 4;
  localparam int SUM_W       = 11;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_BYTES = 2'd1;

  typedef enum logic [1:0] {
    MODE_B4  = 2'd0,
    MODE_B8  = 2'd1,
    MODE_B16 = 2'd2
  } mode_t;

  typedef struct packed {
    logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits;
    logic [SLOT_W-1:0]                  count;
    logic [SLOT_W-1:0]                  chk_start;
    logic                               msg_end;
  } job_t;

endpackage

@@ rtl/core/wbwc_intf.sv @@
// Channel interfaces: message bytes in, digits out, configuration writes.
interface wbwc_byte_if;
  logic                             valid;
  logic                             ready;
  logic [wbwc_pkg::BYTE_W-1:0]      msg_byte;

  modport source (output valid, output msg_byte, input ready);
  modport sink   (input valid, input msg_byte, output ready);
endinterface

interface wbwc_digit_if;
  logic                             valid;
  logic                             ready;
  logic [wbwc_pkg::DIGIT_W-1:0]     digit;
  logic                             is_checksum;
  logic                             last;

  modport source (output valid, output digit, output is_checksum, output last, input ready);
  modport sink   (input valid, input digit, input is_checksum, input last, output ready);
endinterface

interface wbwc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [wbwc_pkg::CFG_IDX_W-1:0]    index;
  logic [wbwc_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/wbwc_front.sv @@
// Front end: config registers, byte slicing, running checksum, job build.
module wbwc_front #(
  parameter int MAX_HASH_BYTES = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  wbwc_byte_if.sink            bytes,
  wbwc_cfg_if.sink             cfg,
  output logic                 push,
  output wbwc_pkg::job_t       push_job,
  input  logic                 full
);

  localparam logic [6:0] MAX_N = 7'(MAX_HASH_BYTES);

  wbwc_pkg::mode_t                 mode;
  logic [5:0]                      n_eff;
  logic [5:0]                      byte_count;
  logic [wbwc_pkg::SUM_W-1:0]      acc;
  logic [1:0]                      lbuf;
  logic [1:0]                      lfill;

  logic                            accept;
  logic                            first;
  logic                            end_msg;
  logic [1:0]                      fill0;
  logic [1:0]                      buf0;
  logic [9:0]                      v;
  logic [3:0]                      mask;
  logic [3:0]                      md [4];
  logic [2:0]                      mc;
  logic [1:0]                      nf;
  logic [1:0]                      nb;
  logic [5:0]                      comp;
  logic [wbwc_pkg::SUM_W-1:0]      sum_next;
  logic [11:0]                     s12;
  logic [3:0]                      chk [5];
  logic [2:0]                      nchk;
  logic [wbwc_pkg::MAX_DIGITS-1:0][wbwc_pkg::DIGIT_W-1:0] slots;
  logic [5:0]                      hb;
  logic [5:0]                      hb_eff;

  assign bytes.ready = !full;
  assign cfg.ready   = 1'b1;
  assign accept      = bytes.valid && !full;
  assign push        = accept;

  assign first   = (byte_count == 6'd0);
  assign end_msg = (byte_count == n_eff - 6'd1);
  assign fill0   = first ? 2'd0 : lfill;
  assign buf0    = first ? 2'd0 : lbuf;
  assign v       = {buf0, bytes.msg_byte};

  assign hb     = cfg.data[5:0];
  assign hb_eff = (hb == 6'd0) ? 6'd1 : (({1'b0, hb} > MAX_N) ? MAX_N[5:0] : hb);

  always_comb begin
    md   = '{default: '0};
    mc   = 3'd0;
    nf   = 2'd0;
    nb   = 2'd0;
    mask = 4'hf;
    case (mode)
      wbwc_pkg::MODE_B4: begin
        mask  = 4'h3;
        md[0] = {2'b00, v[7:6]};
        md[1] = {2'b00, v[5:4]};
        md[2] = {2'b00, v[3:2]};
        md[3] = {2'b00, v[1:0]};
        mc    = 3'd4;
      end
      wbwc_pkg::MODE_B8: begin
        mask = 4'h7;
        case (fill0)
          2'd1: begin
            md[0] = {1'b0, v[8:6]};
            md[1] = {1'b0, v[5:3]};
            md[2] = {1'b0, v[2:0]};
            mc    = 3'd3;
          end
          2'd2: begin
            md[0] = {1'b0, v[9:7]};
            md[1] = {1'b0, v[6:4]};
            md[2] = {1'b0, v[3:1]};
            mc    = 3'd3;
            nf    = 2'd1;
            nb    = {1'b0, v[0]};
          end
          default: begin
            md[0] = {1'b0, v[7:5]};
            md[1] = {1'b0, v[4:2]};
            mc    = 3'd2;
            nf    = 2'd2;
            nb    = v[1:0];
          end
        endcase
        // zero pad completes the final digit
        if (end_msg && nf != 2'd0) begin
          md[mc[1:0]] = (nf == 2'd2) ? {1'b0, nb, 1'b0} : {1'b0, nb[0], 2'b00};
          mc          = mc + 3'd1;
        end
      end
      default: begin
        md[0] = v[7:4];
        md[1] = v[3:0];
        mc    = 3'd2;
      end
    endcase
  end

  // inverted sum accumulated as the sum of (w-1-d) over message digits
  always_comb begin
    comp = 6'd0;
    for (int s = 0; s < 4; s++) begin
      if (3'(s) < mc) begin
        comp = comp + 6'(mask - md[s]);
      end
    end
    sum_next = (first ? '0 : acc) + wbwc_pkg::SUM_W'(comp);
    s12      = {1'b0, sum_next};
  end

  always_comb begin
    chk  = '{default: '0};
    nchk = 3'd3;
    case (mode)
      wbwc_pkg::MODE_B4: begin
        if (n_eff >= 6'd24) begin
          nchk   = 3'd5;
          chk[0] = {2'b00, s12[9:8]};
          chk[1] = {2'b00, s12[7:6]};
          chk[2] = {2'b00, s12[5:4]};
          chk[3] = {2'b00, s12[3:2]};
          chk[4] = {2'b00, s12[1:0]};
        end else begin
          nchk   = 3'd4;
          chk[0] = {2'b00, s12[7:6]};
          chk[1] = {2'b00, s12[5:4]};
          chk[2] = {2'b00, s12[3:2]};
          chk[3] = {2'b00, s12[1:0]};
        end
      end
      wbwc_pkg::MODE_B8: begin
        if (n_eff >= 6'd32) begin
          nchk   = 3'd4;
          chk[0] = {1'b0, s12[11:9]};
          chk[1] = {1'b0, s12[8:6]};
          chk[2] = {1'b0, s12[5:3]};
          chk[3] = {1'b0, s12[2:0]};
        end else begin
          chk[0] = {1'b0, s12[8:6]};
          chk[1] = {1'b0, s12[5:3]};
          chk[2] = {1'b0, s12[2:0]};
        end
      end
      default: begin
        chk[0] = s12[11:8];
        chk[1] = s12[7:4];
        chk[2] = s12[3:0];
      end
    endcase
  end

  always_comb begin
    slots = '0;
    for (int s = 0; s < 4; s++) begin
      if (3'(s) < mc) begin
        slots[s] = md[s];
      end
    end
    for (int j = 0; j < 5; j++) begin
      if (end_msg && 3'(j) < nchk) begin
        slots[4'({1'b0, mc}) + 4'(j)] = chk[j];
      end
    end
    push_job.digits    = slots;
    push_job.chk_start = {1'b0, mc};
    push_job.count     = {1'b0, mc} + (end_msg ? {1'b0, nchk} : 4'd0);
    push_job.msg_end   = end_msg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= wbwc_pkg::MODE_B16;
      n_eff      <= 6'd16;
      byte_count <= 6'd0;
      acc        <= '0;
      lbuf       <= 2'd0;
      lfill      <= 2'd0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        wbwc_pkg::REG_DIGIT_BITS: begin
          unique case (cfg.data[2:0]) inside
            3'd0, 3'd1, 3'd2: mode <= wbwc_pkg::MODE_B4;
            3'd3:             mode <= wbwc_pkg::MODE_B8;
            default:          mode <= wbwc_pkg::MODE_B16;
          endcase
          byte_count <= 6'd0;
          acc        <= '0;
          lbuf       <= 2'd0;
          lfill      <= 2'd0;
        end
        wbwc_pkg::REG_HASH_BYTES: begin
          n_eff      <= hb_eff;
          byte_count <= 6'd0;
          acc        <= '0;
          lbuf       <= 2'd0;
          lfill      <= 2'd0;
        end
        default: ;
      endcase
    end else if (accept) begin
      if (end_msg) begin
        byte_count <= 6'd0;
        acc        <= '0;
        lbuf       <= 2'd0;
        lfill      <= 2'd0;
      end else begin
        byte_count <= byte_count + 6'd1;
        acc        <= sum_next;
        lbuf       <= nb;
        lfill      <= nf;
      end
    end
  end

endmodule

@@ rtl/core/wbwc_queue.sv @@
// Job queue between the front end and the digit emitter.
module wbwc_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  wbwc_pkg::job_t       push_job,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output wbwc_pkg::job_t       head_job
);

  localparam int PTR_W = $clog2(wbwc_pkg::QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(wbwc_pkg::QUEUE_DEPTH - 1);
  localparam logic [PTR_W:0]   DEPTH_N  = (PTR_W + 1)'(wbwc_pkg::QUEUE_DEPTH);

  wbwc_pkg::job_t    entries [wbwc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W:0]    fill;

  assign full       = (fill == DEPTH_N);
  assign head_valid = (fill != '0);
  assign head_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/wbwc_back.sv @@
// Back end: walks each queued job and registers one digit per cycle while the output is not stalled.
module wbwc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  wbwc_pkg::job_t       head_job,
  output logic                 pop,
  wbwc_digit_if.source         digits
);

  logic [wbwc_pkg::SLOT_W-1:0] idx;
  logic                        load;
  logic                        at_end;

  assign load   = head_valid && (!digits.valid || digits.ready);
  assign at_end = (idx == head_job.count - 4'd1);
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (load) begin
      digits.digit       <= head_job.digits[idx];
      digits.is_checksum <= (idx >= head_job.chk_start);
      digits.last        <= at_end && head_job.msg_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digits.valid <= 1'b0;
      idx          <= '0;
    end else if (load) begin
      digits.valid <= 1'b1;
      idx          <= at_end ? '0 : idx + 4'd1;
    end else if (digits.ready) begin
      digits.valid <= 1'b0;
    end
  end

  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> idx < head_job.count)
    else $error("digit index past end of job");

  a_last_is_checksum: assert property (@(posedge clk) disable iff (rst)
    digits.valid && digits.last |-> digits.is_checksum)
    else $error("last digit not a checksum digit");

  a_end_has_checksum: assert property (@(posedge clk) disable iff (rst)
    head_valid && head_job.msg_end |-> head_job.chk_start < head_job.count)
    else $error("message end job without checksum digits");

endmodule

@@ rtl/core/wots_base_w_digits_checksum.sv @@
// Top level: WOTS+ base-w digit generator with appended inverted checksum.
//
//   channel  dir  handshake      payload
//   bytes    in   valid/ready    msg_byte[7:0]
//   digits   out  valid/ready    digit[3:0], is_checksum, last
//   cfg      in   valid/ready    index[1:0], data[7:0] (ready tied high)
//
// One digit leaves the output register per cycle while digits.ready allows, so a byte
// yields 2 digits in base 16, 4 in base 4 and 2 or 3 in base 8; the final byte of a message
// adds any zero-padded digit and the checksum digits (up to 9 digits in total in base 4).
// The front end takes a byte per cycle while the 4-entry job queue has room.
// Synchronous reset: base 16, 16-byte hash, empty queue, no message open.
// Output stalls back up through the queue to bytes.ready.
module wots_base_w_digits_checksum #(
  parameter int MAX_HASH_BYTES = 32
) (
  input  logic          clk,
  input  logic          rst,
  wbwc_byte_if.sink     bytes,
  wbwc_digit_if.source  digits,
  wbwc_cfg_if.sink      cfg
);

  logic            push;
  logic            full;
  logic            pop;
  logic            head_valid;
  wbwc_pkg::job_t  push_job;
  wbwc_pkg::job_t  head_job;

  wbwc_front #(
    .MAX_HASH_BYTES(MAX_HASH_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .bytes    (bytes),
    .cfg      (cfg),
    .push     (push),
    .push_job (push_job),
    .full     (full)
  );

  wbwc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  wbwc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .digits     (digits)
  );

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for wots_base_w_digits_checksum: directed and random messages.
module testbench;

  localparam int HASH_BYTES_MAX = 32;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_ITEMS   = 150;
  localparam int STEADY_ITEMS   = 40;
  localparam int MAX_REPORTS    = 10;

  localparam logic [wbwc_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [wbwc_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam logic [127:0] DEFAULT_MSG = 128'h00FF0FF0A55A3CC301807E81FFFF0000;
  localparam logic [63:0]  WIDTH_MSG   = 64'h00FF00FF00FF5AA5;

  typedef enum int {FILL_RANDOM, FILL_ZEROS, FILL_ONES} fill_t;

  typedef struct packed {
    logic [wbwc_pkg::DIGIT_W-1:0] digit;
    logic                         is_checksum;
    logic                         last;
  } digit_rec_t;

  logic clk = 1'b0;
  logic rst;

  wbwc_byte_if  byte_ch();
  wbwc_digit_if digit_ch();
  wbwc_cfg_if   cfg_ch();

  wots_base_w_digits_checksum #(.MAX_HASH_BYTES(HASH_BYTES_MAX)) dut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (byte_ch),
    .digits (digit_ch),
    .cfg    (cfg_ch)
  );

  // predictor state
  logic [2:0]                 cfg_digit_bits;
  logic [5:0]                 cfg_hash_bytes;
  logic [5:0]                 msg_bytes_seen;
  logic [wbwc_pkg::SUM_W-1:0] inv_sum;
  logic [9:0]                 pend_bits;
  logic [3:0]                 pend_fill;
  logic [6:0]                 msg_digits_done;
  digit_rec_t                 expected_digits[$];

  int mismatches  = 0;
  int idle_cycles = 0;
  int items_sent  = 0;
  int ready_hold  = 0;
  bit idle_on     = 1'b1;

  always #10 clk = ~clk;

  function automatic void clear_message();
    msg_bytes_seen  = '0;
    inv_sum         = '0;
    pend_bits       = '0;
    pend_fill       = '0;
    msg_digits_done = '0;
  endfunction

  function automatic int msg_length();
    if (cfg_hash_bytes == 6'd0) return 1;
    if (cfg_hash_bytes > HASH_BYTES_MAX) return HASH_BYTES_MAX;
    return int'(cfg_hash_bytes);
  endfunction

  function automatic void push_digit(int d, bit chk);
    digit_rec_t r;
    r.digit       = d[wbwc_pkg::DIGIT_W-1:0];
    r.is_checksum = chk;
    r.last        = 1'b0;
    expected_digits.push_back(r);
    if (!chk) inv_sum -= d[wbwc_pkg::SUM_W-1:0];
  endfunction

  function automatic void apply_reg_write(logic [wbwc_pkg::CFG_IDX_W-1:0] idx,
                                          logic [wbwc_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      wbwc_pkg::REG_DIGIT_BITS: begin
        cfg_digit_bits = data[2:0];
        clear_message();
      end
      wbwc_pkg::REG_HASH_BYTES: begin
        cfg_hash_bytes = data[5:0];
        clear_message();
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_digits(logic [7:0] b);
    int w, n, mask, len1, nchk, start, d, sum;
    int s;
    w     = (cfg_digit_bits <= 3'd2) ? 2 : (cfg_digit_bits == 3'd3) ? 3 : 4;
    n     = msg_length();
    mask  = (1 << w) - 1;
    len1  = (w == 3) ? (8 * n + 2) / 3 : (8 * n) / w;
    start = expected_digits.size();
    if (msg_bytes_seen == 6'd0) begin
      inv_sum         = wbwc_pkg::SUM_W'(len1 * mask);
      pend_bits       = '0;
      pend_fill       = '0;
      msg_digits_done = '0;
    end
    if (w == 3) begin
      pend_bits = {pend_bits[1:0], b};
      pend_fill += 4'd8;
      while (pend_fill >= 3 && msg_digits_done < len1) begin
        pend_fill -= 4'd3;
        push_digit((pend_bits >> pend_fill) & 7, 1'b0);
        pend_bits &= (10'd1 << pend_fill) - 10'd1;
        msg_digits_done++;
      end
    end else begin
      for (s = 8 - w; s >= 0; s -= w) push_digit((b >> s) & mask, 1'b0);
    end
    msg_bytes_seen++;
    if (msg_bytes_seen < n) return;
    if (w == 3) begin
      // last message digit padded with zero bits
      while (msg_digits_done < len1 && expected_digits.size() - start < 5) begin
        if (pend_fill >= 3) begin
          pend_fill -= 4'd3;
          d = (pend_bits >> pend_fill) & 7;
          pend_bits &= (10'd1 << pend_fill) - 10'd1;
        end else begin
          d = (pend_bits << (3 - pend_fill)) & 7;
          pend_bits = '0;
          pend_fill = '0;
        end
        push_digit(d, 1'b0);
        msg_digits_done++;
      end
      nchk = (n >= 32) ? 4 : 3;
    end else if (w == 2) begin
      nchk = (n >= 24) ? 5 : 4;
    end else begin
      nchk = 3;
    end
    sum = int'(inv_sum);
    for (int i = 0; i < nchk; i++) push_digit((sum >> (w * (nchk - 1 - i))) & mask, 1'b1);
    expected_digits[expected_digits.size() - 1].last = 1'b1;
    clear_message();
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    @(negedge clk);
    byte_ch.valid    <= 1'b1;
    byte_ch.msg_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
    predict_digits(b);
    items_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      @(negedge clk);
      byte_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_message(input int count, input fill_t fill);
    for (int i = 0; i < count; i++) begin
      case (fill)
        FILL_ZEROS: send_byte(8'h00);
        FILL_ONES:  send_byte(8'hFF);
        default:    send_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    byte_ch.valid <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk);
  endtask

  // upper data bits are don't-care and get random values
  task automatic write_reg(input logic [wbwc_pkg::CFG_IDX_W-1:0] idx, input int value);
    logic [wbwc_pkg::CFG_DATA_W-1:0] data;
    data = wbwc_pkg::CFG_DATA_W'($urandom);
    if (idx == wbwc_pkg::REG_DIGIT_BITS) data[2:0] = value[2:0];
    else if (idx == wbwc_pkg::REG_HASH_BYTES) data[5:0] = value[5:0];
    wait_drained();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_reg_write(idx, data);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_random_phase(input bit allow_broken);
    int r, pick, reps;
    fill_t fill;
    write_reg(wbwc_pkg::REG_DIGIT_BITS, $urandom_range(0, 7));
    pick = $urandom_range(0, 15);
    case (pick)
      10:      write_reg(wbwc_pkg::REG_HASH_BYTES, 0);
      11:      write_reg(wbwc_pkg::REG_HASH_BYTES, 16);
      12:      write_reg(wbwc_pkg::REG_HASH_BYTES, 24);
      13:      write_reg(wbwc_pkg::REG_HASH_BYTES, 32);
      14:      write_reg(wbwc_pkg::REG_HASH_BYTES, $urandom_range(33, 63));
      15:      write_reg(wbwc_pkg::REG_HASH_BYTES, $urandom_range(7, 31));
      default: write_reg(wbwc_pkg::REG_HASH_BYTES, $urandom_range(1, 6));
    endcase
    if (allow_broken && $urandom_range(0, 7) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, 0);
    reps = $urandom_range(1, 3);
    repeat (reps) begin
      r = $urandom_range(0, 7);
      fill = (r == 0) ? FILL_ZEROS : (r == 1) ? FILL_ONES : FILL_RANDOM;
      send_message(msg_length(), fill);
    end
    // message left open, dropped by the next register write
    if (allow_broken && msg_length() > 1 && $urandom_range(0, 3) == 0)
      send_message($urandom_range(1, msg_length() - 1), FILL_RANDOM);
  endtask

  task automatic test_reset_defaults();
    for (int i = 0; i < 16; i++) send_byte(DEFAULT_MSG[127 - 8 * i -: 8]);
  endtask

  task automatic test_digit_widths();
    write_reg(wbwc_pkg::REG_HASH_BYTES, 1);
    for (int v = 0; v < 8; v++) begin
      write_reg(wbwc_pkg::REG_DIGIT_BITS, v);
      send_byte(WIDTH_MSG[63 - 8 * v -: 8]);
    end
    write_reg(wbwc_pkg::REG_DIGIT_BITS, 3);
    write_reg(wbwc_pkg::REG_HASH_BYTES, 2);
    send_byte(8'hFF);
    send_byte(8'h00);
    write_reg(wbwc_pkg::REG_HASH_BYTES, 0);
    send_byte(8'h81);
  endtask

  task automatic test_register_rules();
    write_reg(wbwc_pkg::REG_HASH_BYTES, 63);
    write_reg(REG_SPARE_2, 0);
    write_reg(REG_SPARE_3, 0);
    write_reg(wbwc_pkg::REG_HASH_BYTES, 2);
    write_reg(wbwc_pkg::REG_DIGIT_BITS, 2);
    send_byte(8'h3C);
    write_reg(REG_SPARE_3, 0);
    send_byte(8'hC3);
    send_byte(8'h7E);
    write_reg(wbwc_pkg::REG_DIGIT_BITS, 4);
    send_message(2, FILL_RANDOM);
  endtask

  task automatic test_random_messages();
    while (items_sent < RANDOM_ITEMS) run_random_phase(1'b1);
  endtask

  task automatic test_steady_stream();
    int stop;
    stop    = items_sent + STEADY_ITEMS;
    idle_on = 1'b0;
    while (items_sent < stop) run_random_phase(1'b0);
  endtask

  always @(negedge clk) begin
    if (ready_hold > 0) begin
      digit_ch.ready <= 1'b0;
      ready_hold--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      digit_ch.ready <= 1'b0;
      ready_hold = $urandom_range(0, 2);
    end else begin
      digit_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    digit_rec_t want;
    if (!rst && digit_ch.valid && digit_ch.ready) begin
      if (expected_digits.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected digit transaction at %0t: digit=%0d chk=%0b last=%0b",
                   $time, digit_ch.digit, digit_ch.is_checksum, digit_ch.last);
      end else begin
        want = expected_digits.pop_front();
        if (digit_ch.digit !== want.digit || digit_ch.is_checksum !== want.is_checksum ||
            digit_ch.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("digit mismatch at %0t: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                     $time, want.digit, want.is_checksum, want.last,
                     digit_ch.digit, digit_ch.is_checksum, digit_ch.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((byte_ch.valid && byte_ch.ready) || (digit_ch.valid && digit_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst              = 1'b1;
    byte_ch.valid    = 1'b0;
    byte_ch.msg_byte = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    digit_ch.ready   = 1'b0;
    cfg_digit_bits   = 3'd4;
    cfg_hash_bytes   = 6'd16;
    clear_message();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_digit_widths();
    test_register_rules();
    test_random_messages();
    test_steady_stream();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatches += expected_digits.size();
    if (mismatches == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule
